>>> hdl/somt_pkg.sv
// ----------------------------------------------------------------------------
// somt_pkg: shared definitions for the second-order map particle tracker
// Fixed-point format, coefficient store layout and saturating helpers.
// ----------------------------------------------------------------------------
package somt_pkg;

  localparam int WORD_BITS   = 48;
  localparam int FRAC_BITS   = 32;
  localparam int COORD_COUNT = 6;
  localparam int MAT_SIZE    = COORD_COUNT * COORD_COUNT;
  localparam int TEN_SIZE    = MAT_SIZE * COORD_COUNT;
  localparam int MEM_DEPTH   = 4 * MAT_SIZE + TEN_SIZE - MAT_SIZE + 2 * COORD_COUNT;
  localparam int ADDR_BITS   = $clog2(MEM_DEPTH);
  localparam int PROD_BITS   = 2 * WORD_BITS;
  localparam int SLICE_BITS  = 16;
  localparam int SLICE_COUNT = WORD_BITS / SLICE_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        mag_t;
  typedef logic [ADDR_BITS-1:0]        addr_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Table selects.
  localparam logic [2:0] TBL_LIN  = 3'd0;
  localparam logic [2:0] TBL_TEN  = 3'd1;
  localparam logic [2:0] TBL_ROT1 = 3'd2;
  localparam logic [2:0] TBL_ROT2 = 3'd3;
  localparam logic [2:0] TBL_SH1  = 3'd4;
  localparam logic [2:0] TBL_SH2  = 3'd5;

  // Processing phases of a track transaction, in order.
  localparam logic [2:0] PH_SH1  = 3'd0;
  localparam logic [2:0] PH_ROT1 = 3'd1;
  localparam logic [2:0] PH_LIN  = 3'd2;
  localparam logic [2:0] PH_TEN  = 3'd3;
  localparam logic [2:0] PH_ROT2 = 3'd4;
  localparam logic [2:0] PH_SH2  = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  // Start of each table in the shared coefficient store.
  function automatic addr_t tbl_base(input logic [2:0] sel);
    case (sel)
      TBL_LIN:  tbl_base = addr_t'(0);
      TBL_TEN:  tbl_base = addr_t'(MAT_SIZE);
      TBL_ROT1: tbl_base = addr_t'(MAT_SIZE + TEN_SIZE);
      TBL_ROT2: tbl_base = addr_t'(2 * MAT_SIZE + TEN_SIZE);
      TBL_SH1:  tbl_base = addr_t'(3 * MAT_SIZE + TEN_SIZE);
      TBL_SH2:  tbl_base = addr_t'(3 * MAT_SIZE + TEN_SIZE + COORD_COUNT);
      default:  tbl_base = addr_t'(0);
    endcase
  endfunction

  // Number of entries of each table; an unknown select has none.
  function automatic logic [8:0] tbl_size(input logic [2:0] sel);
    case (sel)
      TBL_LIN, TBL_ROT1, TBL_ROT2: tbl_size = 9'(MAT_SIZE);
      TBL_TEN:                     tbl_size = 9'(TEN_SIZE);
      TBL_SH1, TBL_SH2:            tbl_size = 9'(COORD_COUNT);
      default:                     tbl_size = 9'd0;
    endcase
  endfunction

  // Table used by each phase.
  function automatic logic [2:0] phase_tbl(input logic [2:0] ph);
    case (ph)
      PH_SH1:  phase_tbl = TBL_SH1;
      PH_ROT1: phase_tbl = TBL_ROT1;
      PH_LIN:  phase_tbl = TBL_LIN;
      PH_TEN:  phase_tbl = TBL_TEN;
      PH_ROT2: phase_tbl = TBL_ROT2;
      PH_SH2:  phase_tbl = TBL_SH2;
      default: phase_tbl = TBL_LIN;
    endcase
  endfunction

  // First enabled phase at or after ph; linear and tensor always run.
  function automatic logic [2:0] first_phase(input logic [2:0] ph, input logic [3:0] en);
    logic [5:0] on;
    logic       found;
    first_phase = PH_DONE;
    found       = 1'b0;
    on          = {en[3], en[2], 1'b1, 1'b1, en[1], en[0]};
    for (int p = 0; p < 6; p++) begin
      if (!found && (3'(p) >= ph) && on[p]) begin
        first_phase = 3'(p);
        found       = 1'b1;
      end
    end
  endfunction

  // Saturating add at the word range.
  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      sat_add = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      sat_add = s[WORD_BITS-1:0];
    end
  endfunction

  // Magnitude of a word; the most negative value maps to 2^(WORD_BITS-1).
  function automatic mag_t word_mag(input word_t a);
    word_mag = a[WORD_BITS-1] ? mag_t'(-a) : mag_t'(a);
  endfunction

endpackage

>>> hdl/second_order_map_particle_track_core.sv
// ----------------------------------------------------------------------------
// second_order_map_particle_track_core: six-coordinate second-order tracker
// Loads coefficient tables and tracks particles through a beam element.
// ----------------------------------------------------------------------------
// Usage: all tables share one single-port coefficient memory (336 words,
// registered read) feeding one shared multiplier that sums three 48x16
// partial products and then rounds. A load transaction writes the store
// and leaves the input ready. A track of a live particle reads, multiplies
// and accumulates each matrix entry, and for each (j,k) pair of the tensor
// forms r_j*r_k and applies it to every row; the linear map and the kick
// always run, each rotation and shift only when enabled. A lost particle
// skips every phase. One transaction is processed at a time. Every
// coefficient that a track reads must have been loaded first.
module second_order_map_particle_track_core
  import somt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration writes.
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic          cfg_wdata_i,
  // Input stream.
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // coeff_index[7:0], coeff_value[55:8], x_in[103:56], px_in[151:104],
  // y_in[199:152], py_in[247:200], dp_in[295:248], ct_in[343:296]
  input  logic [343:0]  s_axis_tdata_i,
  // func[0], table_select[3:1], lost_in[4]
  input  logic [4:0]    s_axis_tuser_i,
  input  logic          s_axis_tlast_i,
  // Output stream.
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // x_out[47:0], px_out[95:48], y_out[143:96], py_out[191:144],
  // dp_out[239:192], ct_out[287:240]
  output logic [287:0]  m_axis_tdata_o,
  // lost_out[0]
  output logic [0:0]    m_axis_tuser_o,
  output logic          m_axis_tlast_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NEXT   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_USE    = 4'd3;
  localparam logic [3:0] S_QSTART = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_FIN    = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  localparam logic [2:0] LAST_IDX = 3'(COORD_COUNT - 1);

  // Configuration registers.
  logic [3:0] en_q;  // exit shift, exit rotation, entrance rotation, entrance shift

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else if (cfg_we_i) begin
      en_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Control and datapath registers.
  logic [3:0]  st_q;
  logic [2:0]  phase_q;
  logic [2:0]  i_q, j_q, k_q;
  logic [1:0]  mcnt_q;
  logic        qmul_q, neg_q;
  mag_t        mag_a_q, mag_b_q;
  logic [PROD_BITS-1:0] prod_q;
  word_t       v_q, p_q, rdata_q;
  word_t       r_q   [COORD_COUNT];
  word_t       rk_q  [COORD_COUNT];
  word_t       acc_q [COORD_COUNT];
  logic        lost_q, last_q;
  logic        ovalid_q;
  logic [287:0] odata_q;
  logic        olost_q, olast_q;

  // Input fields.
  logic        in_func, in_lost;
  logic [2:0]  in_sel;
  logic [7:0]  in_idx;
  word_t       in_val;
  logic        accept;

  assign in_func = s_axis_tuser_i[0];
  assign in_sel  = s_axis_tuser_i[3:1];
  assign in_lost = s_axis_tuser_i[4];
  assign in_idx  = s_axis_tdata_i[7:0];
  assign in_val  = s_axis_tdata_i[55:8];
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (st_q == S_IDLE);

  // Coefficient store write on a load transaction with a valid target.
  logic  mem_we;
  addr_t mem_waddr;
  assign mem_we    = accept && !in_func && (9'(in_idx) < tbl_size(in_sel));
  assign mem_waddr = tbl_base(in_sel) + addr_t'(in_idx);

  // Read address from the phase table and the loop counters.
  addr_t rd_addr;
  assign rd_addr = tbl_base(phase_tbl(phase_q)) + addr_t'(i_q)
                 + addr_t'(6 * i_q - 6 * i_q + 6 * j_q) + addr_t'(36 * k_q);

  word_t mem_q [MEM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_val;
    end
    if (st_q == S_RD) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Rounding and saturation of the finished product.
  logic [PROD_BITS:0]           rounded;
  logic [PROD_BITS-FRAC_BITS:0] mlo;
  word_t                        prod_word;
  always_comb begin
    rounded = {1'b0, prod_q} + (PROD_BITS+1)'(1) * ((PROD_BITS+1)'(1) << (FRAC_BITS - 1));
    mlo     = rounded[PROD_BITS:FRAC_BITS];
    if (neg_q) begin
      if (mlo > (PROD_BITS-FRAC_BITS+1)'(WORD_MAX) + 1'b1) begin
        prod_word = WORD_MIN;
      end else begin
        prod_word = -word_t'(mlo[WORD_BITS-1:0]);
      end
    end else if (mlo > (PROD_BITS-FRAC_BITS+1)'(WORD_MAX)) begin
      prod_word = WORD_MAX;
    end else begin
      prod_word = word_t'(mlo[WORD_BITS-1:0]);
    end
  end

  // One partial product of the shared multiplier.
  logic [WORD_BITS+SLICE_BITS-1:0] pp;
  assign pp = mag_a_q * mag_b_q[mcnt_q*SLICE_BITS +: SLICE_BITS];

  logic is_shift, is_ten;
  assign is_shift = (phase_q == PH_SH1) || (phase_q == PH_SH2);
  assign is_ten   = (phase_q == PH_TEN);

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      phase_q  <= PH_DONE;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      mcnt_q   <= '0;
      qmul_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      // The output register is loaded from S_DONE once it is free.
      if ((st_q == S_DONE) && (!ovalid_q || m_axis_tready_i)) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (accept && in_func) begin
            for (int n = 0; n < COORD_COUNT; n++) begin
              r_q[n] <= s_axis_tdata_i[56 + WORD_BITS*n +: WORD_BITS];
            end
            lost_q  <= in_lost;
            last_q  <= s_axis_tlast_i;
            phase_q <= in_lost ? PH_DONE : first_phase(PH_SH1, en_q);
            st_q    <= S_NEXT;
          end
        end
        // Start of a phase.
        S_NEXT: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
          for (int n = 0; n < COORD_COUNT; n++) begin
            acc_q[n] <= '0;
            rk_q[n]  <= r_q[n];
          end
          v_q <= r_q[0];
          if (phase_q == PH_DONE) begin
            st_q <= S_DONE;
          end else if (phase_q == PH_TEN) begin
            st_q <= S_QSTART;
          end else begin
            st_q <= S_RD;
          end
        end
        S_RD: begin
          st_q <= S_USE;
        end
        S_USE: begin
          if (is_shift) begin
            r_q[i_q] <= sat_add(r_q[i_q], rdata_q);
            if (i_q == LAST_IDX) begin
              phase_q <= first_phase(phase_q + 3'd1, en_q);
              st_q    <= S_NEXT;
            end else begin
              i_q  <= i_q + 3'd1;
              st_q <= S_RD;
            end
          end else begin
            mag_a_q <= word_mag(rdata_q);
            mag_b_q <= word_mag(v_q);
            neg_q   <= rdata_q[WORD_BITS-1] ^ v_q[WORD_BITS-1];
            prod_q  <= '0;
            mcnt_q  <= '0;
            st_q    <= S_MUL;
          end
        end
        // Product r_j * r_k for the tensor column.
        S_QSTART: begin
          mag_a_q <= word_mag(r_q[j_q]);
          mag_b_q <= word_mag(rk_q[0]);
          neg_q   <= r_q[j_q][WORD_BITS-1] ^ rk_q[0][WORD_BITS-1];
          prod_q  <= '0;
          mcnt_q  <= '0;
          qmul_q  <= 1'b1;
          st_q    <= S_MUL;
        end
        S_MUL: begin
          prod_q <= prod_q + (PROD_BITS'(pp) << (mcnt_q * SLICE_BITS));
          if (mcnt_q == 2'(SLICE_COUNT - 1)) begin
            st_q <= S_FIN;
          end else begin
            mcnt_q <= mcnt_q + 2'd1;
          end
        end
        S_FIN: begin
          p_q  <= prod_word;
          st_q <= S_ACC;
        end
        S_ACC: begin
          if (qmul_q) begin
            v_q    <= p_q;
            qmul_q <= 1'b0;
            st_q   <= S_RD;
          end else begin
            acc_q[i_q] <= sat_add(acc_q[i_q], p_q);
            if (i_q != LAST_IDX) begin
              i_q  <= i_q + 3'd1;
              st_q <= S_RD;
            end else begin
              i_q <= '0;
              if (!is_ten) begin
                // Matrix: next column, or the rows replace the vector.
                if (j_q != LAST_IDX) begin
                  j_q  <= j_q + 3'd1;
                  v_q  <= r_q[j_q + 3'd1];
                  st_q <= S_RD;
                end else begin
                  for (int n = 0; n < COORD_COUNT - 1; n++) begin
                    r_q[n] <= acc_q[n];
                  end
                  r_q[COORD_COUNT-1] <= sat_add(acc_q[COORD_COUNT-1], p_q);
                  phase_q <= first_phase(phase_q + 3'd1, en_q);
                  st_q    <= S_NEXT;
                end
              end else begin
                // Tensor: k inner, j outer; the k ring turns every column.
                for (int n = 0; n < COORD_COUNT - 1; n++) begin
                  rk_q[n] <= rk_q[n+1];
                end
                rk_q[COORD_COUNT-1] <= rk_q[0];
                if (k_q != LAST_IDX) begin
                  k_q  <= k_q + 3'd1;
                  st_q <= S_QSTART;
                end else if (j_q != LAST_IDX) begin
                  k_q  <= '0;
                  j_q  <= j_q + 3'd1;
                  st_q <= S_QSTART;
                end else begin
                  for (int n = 0; n < COORD_COUNT - 1; n++) begin
                    r_q[n] <= sat_add(r_q[n], acc_q[n]);
                  end
                  r_q[COORD_COUNT-1] <= sat_add(r_q[COORD_COUNT-1],
                                                sat_add(acc_q[COORD_COUNT-1], p_q));
                  phase_q <= first_phase(phase_q + 3'd1, en_q);
                  st_q    <= S_NEXT;
                end
              end
            end
          end
        end
        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!ovalid_q || m_axis_tready_i) begin
            for (int n = 0; n < COORD_COUNT; n++) begin
              odata_q[WORD_BITS*n +: WORD_BITS] <= r_q[n];
            end
            olost_q  <= lost_q;
            olast_q  <= last_q;
            st_q     <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o   = ovalid_q;
  assign m_axis_tdata_o    = odata_q;
  assign m_axis_tuser_o[0] = olost_q;
  assign m_axis_tlast_o    = olast_q;

endmodule

>>> hdl/somt_checker.sv
// ----------------------------------------------------------------------------
// somt_checker: port-level checks for the particle tracker
// Watches the stream ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module somt_checker
  import somt_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [4:0]   s_axis_tuser_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [287:0] m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result transaction withdrawn while stalled");

  // A stalled result keeps its coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  // A load transaction leaves the block ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !s_axis_tuser_i[0] |=> s_axis_tready_o)
    else $error("load transaction stalled the input");

  // A track transaction closes the input once it is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser_i[0] |=> !s_axis_tready_o)
    else $error("input reopened during a track transaction");

endmodule

bind second_order_map_particle_track_core somt_checker u_somt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
